/* hdl/jpdd_pkg.sv */
// Package with shared types, constants and table functions for the joystick drive mixer.
`default_nettype none
package jpdd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STOP_ECHO = 2'd0;
    localparam logic [1:0] CFG_SPEED_FLOOR = 2'd1;
    localparam logic [1:0] CFG_SPEED_TOP = 2'd2;

    // Drive direction codes.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 41;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Division by 100 as a multiply by a rounded-up reciprocal; exact below 2^18.
    localparam int RECIP_SHIFT = 25;
    localparam logic [18:0] RECIP_100 = 19'd335545;

    localparam logic [63:0] DEG_Q40 = 64'd19190098069;

    typedef enum logic [3:0] {
        S_IDLE, S_SQA, S_SQB, S_ROOT, S_SPD, S_DIV1,
        S_ANGA, S_ANGB, S_SIDE, S_DIV2, S_DONE
    } t_state;

    function automatic logic [63:0] mul_q40(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah, al, bh, bl;
        ah = a >> 20;
        al = a & 64'hFFFFF;
        bh = b >> 20;
        bl = b & 64'hFFFFF;
        return ah * bh + ((ah * bl + al * bh + ((al * bl) >> 20)) >> 20);
    endfunction

    function automatic logic [63:0] term_div(input logic [63:0] t, input int n);
        logic [63:0] q;
        case (n)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            7:       q = t / 64'd210;
            8:       q = t / 64'd272;
            9:       q = t / 64'd342;
            10:      q = t / 64'd420;
            11:      q = t / 64'd506;
            default: q = t / 64'd600;
        endcase
        return q;
    endfunction

    // Sine of k degrees in Q40 from a thirteen-term Taylor series.
    function automatic logic [40:0] sin_q40(input int k);
        logic [63:0] x, term;
        logic signed [63:0] acc;
        x = 64'(k) * DEG_Q40;
        term = x;
        acc = signed'(x);
        for (int n = 1; n <= 12; n++) begin
            term = term_div(mul_q40(mul_q40(term, x), x), n);
            if ((n % 2) == 1) begin
                acc = acc - signed'(term);
            end else begin
                acc = acc + signed'(term);
            end
        end
        return (acc < 0) ? 41'd0 : 41'(acc);
    endfunction

    // Sector ramp: floor(d * 255 / 88).
    function automatic logic [7:0] ramp_of(input int d);
        return 8'((d * 255) / 88);
    endfunction

endpackage
`default_nettype wire

/* hdl/jpdd_in_if.sv */
// Input channel carrying one joystick sample and one echo time per item.
`default_nettype none
interface jpdd_in_if #(parameter int STICK_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic [STICK_BITS-1:0] stick_x;
    logic [STICK_BITS-1:0] stick_y;
    logic [15:0]           echo_time_us;
    modport source (output valid, stick_x, stick_y, echo_time_us, input ready);
    modport sink (input valid, stick_x, stick_y, echo_time_us, output ready);
endinterface
`default_nettype wire

/* hdl/jpdd_out_if.sv */
// Output channel carrying the drive command item.
`default_nettype none
interface jpdd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic [1:0] drive_dir;
    logic       left_lamp;
    logic       right_lamp;
    logic       rear_lamp;
    logic       alarm;
    modport source (output valid, left_pwm, right_pwm, drive_dir, left_lamp, right_lamp,
                    rear_lamp, alarm, input ready);
    modport sink (input valid, left_pwm, right_pwm, drive_dir, left_lamp, right_lamp,
                  rear_lamp, alarm, output ready);
endinterface
`default_nettype wire

/* hdl/joystick_polar_differential_drive.sv */
// Top level of the joystick mixer for a two-motor differential drive.
//
// Usage: i_in carries one item per joystick sample (stick_x, stick_y and the
// ultrasonic echo time). o_out carries one drive item per input item: the held
// left and right duty, the direction, the three lamps and the alarm. The
// configuration port writes the obstacle threshold, the speed floor and the
// speed top; it is meant to be written only while the block is idle.
// Sequence: a sample runs through one shared multiplier under a small sequencer:
// squaring of each axis, a bit-per-cycle square root, the speed step, a
// divide by 100, a binary search over the sine table for the angle, then the
// ramp side with its divide by 100 and a finishing step that commits to the
// output register. The block takes no new item until the previous one has
// reached the output register.
// Reset clears the held drive state (stopped, duty zero, lamps off) and loads
// the registers with 294, 40 and 100. If the receiver stalls, the finished
// result waits in the output register, a new item can still be accepted, and
// that item waits in its last step until the output register is free.
`default_nettype none
module joystick_polar_differential_drive
    import jpdd_pkg::*;
#(
    parameter int STICK_BITS = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    jpdd_in_if.sink         i_in,
    jpdd_out_if.source      o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    localparam int SB = STICK_BITS;
    localparam int SQ_W = 2 * SB;
    localparam logic [SB-1:0] CENTRE = SB'(1) << (SB - 1);

    // Constant tables: sine in Q40 and the sector ramp.
    logic [40:0] w_sin [0:90];
    logic [7:0]  w_ramp [0:88];
    for (genvar g = 0; g <= 90; g++) begin : g_sin
        assign w_sin[g] = sin_q40(g);
    end
    for (genvar g = 0; g <= 88; g++) begin : g_ramp
        assign w_ramp[g] = ramp_of(g);
    end

    t_state r_state, n_state;

    logic [15:0] r_stop;
    logic [7:0]  r_floor, r_top;

    // Per-item registers.
    logic [SB-1:0]   r_a, r_b;
    logic            r_dxneg, r_dyneg, r_dypos;
    logic [15:0]     r_echo;
    logic [SQ_W-1:0] r_sq, r_rem, r_root, r_bit;
    logic [4:0]      r_cnt;
    logic signed [11:0] r_spd, r_full, r_fl, r_v;
    logic signed [19:0] r_w;
    logic [6:0]      r_lo, r_step;
    logic [MUL_P_W-1:0] r_pa;

    // Output register, which is also the held drive state.
    logic       r_oval;
    logic [7:0] r_lpwm, r_rpwm;
    logic [1:0] r_dir;
    logic       r_llamp, r_rlamp, r_rear, r_alarm;

    // Shared multiplier.
    logic [MUL_A_W-1:0] w_ma;
    logic [MUL_B_W-1:0] w_mb;
    logic [MUL_P_W-1:0] w_prod;
    assign w_prod = MUL_P_W'(w_ma) * MUL_P_W'(w_mb);

    // Search index.
    logic [7:0] w_k;
    logic [6:0] w_ki, w_kc;
    logic       w_k_out;
    assign w_k = {1'b0, r_lo} + {1'b0, r_step};
    assign w_ki = w_k[6:0];
    assign w_kc = 7'(8'd90 - w_k);
    assign w_k_out = (w_k > 8'd89);

    // Speed and divide helpers.
    logic signed [8:0]  w_d;
    logic [9:0]         w_t;
    logic signed [19:0] w_n1, w_n2, w_n, w_nmag;
    logic               w_nneg;
    logic [11:0]        w_q;
    logic signed [11:0] w_qs;
    logic [10:0]        w_spdmag;
    assign w_d = signed'({1'b0, r_top}) - signed'({1'b0, r_floor});
    assign w_t = 10'(w_prod >> (SB - 1));
    assign w_n1 = (20'(r_spd) <<< 8) - 20'(r_spd);
    assign w_spdmag = r_spd[11] ? 11'(-r_spd) : 11'(r_spd);

    // Angle and sector.
    logic       w_a0, w_b0, w_ab, w_exact, w_ramp_side;
    logic [6:0] w_fdeg, w_cdeg;
    logic [8:0] w_pos, w_base;
    logic [7:0] w_m;
    assign w_a0 = (r_a == '0);
    assign w_b0 = (r_b == '0);
    assign w_ab = (r_a == r_b);
    assign w_exact = w_a0 || w_b0 || w_ab;
    assign w_cdeg = w_fdeg + (w_exact ? 7'd0 : 7'd1);

    always_comb begin
        if (w_a0) begin
            w_fdeg = 7'd90;
        end else if (w_b0) begin
            w_fdeg = 7'd0;
        end else if (w_ab) begin
            w_fdeg = 7'd45;
        end else begin
            w_fdeg = r_lo;
        end
        if (w_a0 && w_b0) begin
            w_pos = 9'd0;
        end else if (!r_dyneg) begin
            w_pos = !r_dxneg ? 9'(w_fdeg) : 9'd180 - 9'(w_cdeg);
        end else begin
            w_pos = !r_dxneg ? 9'd360 - 9'(w_fdeg) : 9'd180 + 9'(w_cdeg);
        end
        // Ramp base per sector; the ramp side uses the floored full duty.
        w_ramp_side = 1'b0;
        if (w_pos > 9'd90 && w_pos < 9'd180) begin
            w_base = 9'd91;
        end else if (w_pos > 9'd180 && w_pos < 9'd270) begin
            w_base = 9'd181;
            w_ramp_side = 1'b1;
        end else if (w_pos > 9'd270 && w_pos < 9'd360) begin
            w_base = 9'd271;
        end else begin
            w_base = 9'd1;
            w_ramp_side = (w_pos > 9'd0 && w_pos < 9'd90);
        end
    end
    assign w_m = w_ramp[7'(w_pos - w_base)];

    assign w_n2 = w_ramp_side ? (20'(r_fl) * 20'sd100 - r_w) : r_w;
    assign w_n = (r_state == S_DIV1) ? w_n1 : w_n2;
    assign w_nneg = w_n[19];
    assign w_nmag = w_nneg ? -w_n : w_n;
    assign w_q = 12'(w_prod >> RECIP_SHIFT);
    assign w_qs = w_nneg ? -signed'(w_q) : signed'(w_q);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQA: begin
                w_ma = MUL_A_W'(r_a);
                w_mb = MUL_B_W'(r_a);
            end
            S_SQB: begin
                w_ma = MUL_A_W'(r_b);
                w_mb = MUL_B_W'(r_b);
            end
            S_SPD: begin
                w_ma = MUL_A_W'(r_root[SB-1:0]);
                w_mb = MUL_B_W'(w_d[8] ? 9'(-w_d) : 9'(w_d));
            end
            S_DIV1, S_DIV2: begin
                w_ma = MUL_A_W'(w_nmag);
                w_mb = MUL_B_W'(RECIP_100);
            end
            S_ANGA: begin
                w_ma = MUL_A_W'(r_b);
                w_mb = w_sin[w_kc];
            end
            S_ANGB: begin
                w_ma = MUL_A_W'(r_a);
                w_mb = w_sin[w_ki];
            end
            S_SIDE: begin
                w_ma = MUL_A_W'(w_spdmag);
                w_mb = MUL_B_W'(8'd255 - w_m);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Final drive decision.
    logic signed [11:0] w_lv, w_rv;
    logic       w_lamp_l, w_lamp_r, w_commit, w_centre, w_blocked;
    logic [7:0] w_lclamp, w_rclamp;

    function automatic logic [7:0] clamp12(input logic signed [11:0] v);
        logic [7:0] c;
        if (v < 0) begin
            c = 8'd0;
        end else if (v > 12'sd255) begin
            c = 8'd255;
        end else begin
            c = 8'(v);
        end
        return c;
    endfunction

    always_comb begin
        w_lv = r_full;
        w_rv = r_full;
        w_lamp_l = r_llamp;
        w_lamp_r = r_rlamp;
        if (w_pos == 9'd90 || w_pos == 9'd270) begin
            w_lv = r_full;
            w_rv = r_full;
        end else if (w_pos > 9'd90 && w_pos <= 9'd269) begin
            w_lv = (w_pos == 9'd180) ? 12'sd0 : r_v;
            w_rv = r_full;
            w_lamp_l = 1'b1;
            w_lamp_r = 1'b0;
        end else begin
            w_lv = r_full;
            w_rv = (w_pos == 9'd0 || w_pos == 9'd360) ? 12'sd0 : r_v;
            w_lamp_l = 1'b0;
            w_lamp_r = 1'b1;
        end
    end
    assign w_lclamp = clamp12(w_lv);
    assign w_rclamp = clamp12(w_rv);
    assign w_centre = w_a0 && w_b0;
    assign w_blocked = r_dypos && (r_echo <= r_stop);
    assign w_commit = (r_state == S_DONE) && (!r_oval || o_out.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = (i_in.valid) ? S_SQA : S_IDLE;
            S_SQA:   n_state = S_SQB;
            S_SQB:   n_state = S_ROOT;
            S_ROOT:  n_state = (r_cnt == 5'd1) ? S_SPD : S_ROOT;
            S_SPD:   n_state = S_DIV1;
            S_DIV1:  n_state = S_ANGA;
            S_ANGA: begin
                if (!w_k_out) begin
                    n_state = S_ANGB;
                end else begin
                    n_state = (r_step == 7'd1) ? S_SIDE : S_ANGA;
                end
            end
            S_ANGB:  n_state = (r_step == 7'd1) ? S_SIDE : S_ANGA;
            S_SIDE:  n_state = S_DIV2;
            S_DIV2:  n_state = S_DONE;
            S_DONE:  n_state = w_commit ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        o_out.valid = r_oval;
        o_out.left_pwm = r_lpwm;
        o_out.right_pwm = r_rpwm;
        o_out.drive_dir = r_dir;
        o_out.left_lamp = r_llamp;
        o_out.right_lamp = r_rlamp;
        o_out.rear_lamp = r_rear;
        o_out.alarm = r_alarm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stop <= 16'd294;
            r_floor <= 8'd40;
            r_top <= 8'd100;
            r_oval <= 1'b0;
            r_lpwm <= 8'd0;
            r_rpwm <= 8'd0;
            r_dir <= DIR_STOP;
            r_llamp <= 1'b0;
            r_rlamp <= 1'b0;
            r_rear <= 1'b0;
            r_alarm <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STOP_ECHO:   r_stop <= i_cfg_data;
                    CFG_SPEED_FLOOR: r_floor <= i_cfg_data[7:0];
                    CFG_SPEED_TOP:   r_top <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_oval <= 1'b1;
            end else if (r_oval && o_out.ready) begin
                r_oval <= 1'b0;
            end
            if (w_commit) begin
                r_alarm <= w_blocked;
                r_llamp <= w_centre ? 1'b0 : w_lamp_l;
                r_rlamp <= w_centre ? 1'b0 : w_lamp_r;
                if (w_centre) begin
                    r_lpwm <= 8'd0;
                    r_rpwm <= 8'd0;
                    r_dir <= DIR_STOP;
                    r_rear <= 1'b0;
                end else if (r_dypos) begin
                    r_rear <= 1'b0;
                    if (!w_blocked) begin
                        r_lpwm <= w_lclamp;
                        r_rpwm <= w_rclamp;
                        r_dir <= DIR_FWD;
                    end
                end else if (r_dyneg) begin
                    r_rear <= 1'b1;
                    r_lpwm <= w_lclamp;
                    r_rpwm <= w_rclamp;
                    r_dir <= DIR_REV;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a <= i_in.stick_x[SB-1] ? {1'b0, i_in.stick_x[SB-2:0]}
                                          : CENTRE - i_in.stick_x;
                r_b <= i_in.stick_y[SB-1] ? {1'b0, i_in.stick_y[SB-2:0]}
                                          : CENTRE - i_in.stick_y;
                r_dxneg <= !i_in.stick_x[SB-1];
                r_dyneg <= !i_in.stick_y[SB-1];
                r_dypos <= i_in.stick_y > CENTRE;
                r_echo <= i_in.echo_time_us;
                r_lo <= 7'd0;
                r_step <= 7'd64;
            end
            S_SQA: r_sq <= w_prod[SQ_W-1:0];
            S_SQB: begin
                r_rem <= r_sq + w_prod[SQ_W-1:0];
                r_root <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
                r_cnt <= 5'(SB);
            end
            S_ROOT: begin
                if (r_rem >= r_root + r_bit) begin
                    r_rem <= r_rem - (r_root + r_bit);
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 5'd1;
            end
            S_SPD: begin
                r_spd <= (w_d[8] ? -signed'(12'(w_t)) : signed'(12'(w_t)))
                         + signed'(12'(r_floor));
            end
            S_DIV1: begin
                r_full <= w_qs;
                r_fl <= w_qs - ((w_nneg && (20'(w_q) * 20'd100 != w_nmag)) ? 12'sd1 : 12'sd0);
            end
            S_ANGA: begin
                r_pa <= w_prod;
                if (w_k_out) begin
                    r_step <= r_step >> 1;
                end
            end
            S_ANGB: begin
                if (r_pa >= w_prod) begin
                    r_lo <= w_ki;
                end
                r_step <= r_step >> 1;
            end
            S_SIDE: r_w <= r_spd[11] ? -signed'(20'(w_prod)) : signed'(20'(w_prod));
            S_DIV2: r_v <= w_qs;
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.drive_dir != 2'd3)
        else $error("invalid drive direction");

    a_alarm_rear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.alarm) |-> !o_out.rear_lamp)
        else $error("alarm with reversing light");

    a_step_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANGA || r_state == S_ANGB) |-> $onehot(r_step))
        else $error("search step not a single bit");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the joystick differential drive mixer.
`default_nettype none
module tb_top;
    import jpdd_pkg::*;

    localparam int CENTRE = 512;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] left_pwm;
        logic [7:0] right_pwm;
        logic [1:0] drive_dir;
        logic       left_lamp;
        logic       right_lamp;
        logic       rear_lamp;
        logic       alarm;
    } t_drive_cmd;

    // Holds the mixer's own state and the expected drive commands in order.
    class t_drive_scoreboard;
        longint unsigned sine_q40[91];
        logic [15:0] stop_echo;
        logic [7:0]  speed_lo;
        logic [7:0]  speed_hi;
        t_drive_cmd  held;
        t_drive_cmd  pending_cmds[$];
        int          mismatches;

        function new();
            longint unsigned x, term;
            longint acc;
            for (int k = 0; k <= 90; k++) begin
                x = 64'(k) * DEG_Q40;
                term = x;
                acc = longint'(x);
                for (int n = 1; n <= 12; n++) begin
                    term = qmul(qmul(term, x), x) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) acc = acc - longint'(term);
                    else acc = acc + longint'(term);
                end
                sine_q40[k] = (acc < 0) ? 0 : longint'(acc);
            end
            restore();
            mismatches = 0;
        endfunction

        function longint unsigned qmul(longint unsigned a, longint unsigned b);
            longint unsigned ah, al, bh, bl;
            ah = a >> 20;
            al = a & 64'hFFFFF;
            bh = b >> 20;
            bl = b & 64'hFFFFF;
            return ah * bh + ((ah * bl + al * bh + ((al * bl) >> 20)) >> 20);
        endfunction

        function void restore();
            stop_echo = 16'd294;
            speed_lo = 8'd40;
            speed_hi = 8'd100;
            held = '{8'd0, 8'd0, DIR_STOP, 1'b0, 1'b0, 1'b0, 1'b0};
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_STOP_ECHO:   stop_echo = data;
                CFG_SPEED_FLOOR: speed_lo = data[7:0];
                CFG_SPEED_TOP:   speed_hi = data[7:0];
                default: ;
            endcase
        endfunction

        // Angle in whole degrees, truncated, wrapped into 0..360.
        function longint heading(longint dx, longint dy);
            longint a, b, lo, hi;
            bit exact;
            a = (dx < 0) ? -dx : dx;
            b = (dy < 0) ? -dy : dy;
            if (a == 0 && b == 0) return 0;
            exact = (a == 0 || b == 0 || a == b);
            if (a == 0) lo = 90;
            else if (b == 0) lo = 0;
            else if (a == b) lo = 45;
            else begin
                lo = 0;
                for (int k = 1; k <= 89; k++)
                    if (longint'(b) * sine_q40[90 - k] >= longint'(a) * sine_q40[k]) lo++;
            end
            hi = lo + (exact ? 0 : 1);
            if (dy >= 0) return (dx >= 0) ? lo : 180 - hi;
            return (dx >= 0) ? 360 - lo : 180 + hi;
        endfunction

        function logic [7:0] duty(longint v);
            if (v < 0) return 8'd0;
            if (v > 255) return 8'd255;
            return 8'(v);
        endfunction

        function void note_sample(logic [9:0] sx, logic [9:0] sy, logic [15:0] echo);
            longint dx, dy, pos, len, spd, full, fl, m, lv, rv;
            logic lamp_l, lamp_r;
            t_drive_cmd cmd;
            dx = longint'(sx) - CENTRE;
            dy = longint'(sy) - CENTRE;
            pos = heading(dx, dy);
            len = 0;
            while ((len + 1) * (len + 1) <= dx * dx + dy * dy) len++;
            spd = (len * (longint'(speed_hi) - longint'(speed_lo))) / CENTRE
                  + longint'(speed_lo);
            full = (spd * 255) / 100;
            fl = full;
            if (spd * 255 < 0 && (spd * 255) % 100 != 0) fl = full - 1;
            lamp_l = held.left_lamp;
            lamp_r = held.right_lamp;
            lv = full;
            rv = full;
            if (pos == 90 || pos == 270) begin
            end else if (pos > 90 && pos < 180) begin
                m = ((pos - 91) * 255) / 88;
                lv = (spd * (255 - m)) / 100;
                lamp_l = 1'b1; lamp_r = 1'b0;
            end else if (pos == 180) begin
                lv = 0;
                lamp_l = 1'b1; lamp_r = 1'b0;
            end else if (pos > 180 && pos < 270) begin
                m = ((pos - 181) * 255) / 88;
                lv = (100 * fl - spd * (255 - m)) / 100;
                lamp_l = 1'b1; lamp_r = 1'b0;
            end else if (pos > 270 && pos < 360) begin
                m = ((pos - 271) * 255) / 88;
                rv = (spd * (255 - m)) / 100;
                lamp_l = 1'b0; lamp_r = 1'b1;
            end else if (pos == 0 || pos == 360) begin
                rv = 0;
                lamp_l = 1'b0; lamp_r = 1'b1;
            end else begin
                m = ((pos - 1) * 255) / 88;
                rv = (100 * fl - spd * (255 - m)) / 100;
                lamp_l = 1'b0; lamp_r = 1'b1;
            end
            held.alarm = 1'b0;
            if (dx == 0 && dy == 0) begin
                held.left_pwm = 8'd0;
                held.right_pwm = 8'd0;
                held.drive_dir = DIR_STOP;
                lamp_l = 1'b0; lamp_r = 1'b0;
                held.rear_lamp = 1'b0;
            end else if (dy > 0) begin
                held.rear_lamp = 1'b0;
                if (echo <= stop_echo) begin
                    held.alarm = 1'b1;
                end else begin
                    held.left_pwm = duty(lv);
                    held.right_pwm = duty(rv);
                    held.drive_dir = DIR_FWD;
                end
            end else if (dy < 0) begin
                held.rear_lamp = 1'b1;
                held.left_pwm = duty(lv);
                held.right_pwm = duty(rv);
                held.drive_dir = DIR_REV;
            end
            held.left_lamp = lamp_l;
            held.right_lamp = lamp_r;
            cmd = held;
            pending_cmds.push_back(cmd);
        endfunction

        function void check_command(t_drive_cmd got);
            t_drive_cmd want;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: drive item with none expected");
                return;
            end
            want = pending_cmds.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected pwm %0d/%0d dir %0d lamps %b%b%b alarm %b",
                             want.left_pwm, want.right_pwm, want.drive_dir, want.left_lamp,
                             want.right_lamp, want.rear_lamp, want.alarm);
                    $display("       got      pwm %0d/%0d dir %0d lamps %b%b%b alarm %b",
                             got.left_pwm, got.right_pwm, got.drive_dir, got.left_lamp,
                             got.right_lamp, got.rear_lamp, got.alarm);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    jpdd_in_if #(.STICK_BITS(10)) in_ch();
    jpdd_out_if out_ch();

    joystick_polar_differential_drive #(.STICK_BITS(10)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    t_drive_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  no_gaps = 0;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Mostly short gaps, now and then a long one; none during a burst stretch.
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: ready wanders at random outside burst stretches; items are checked at the rising edge.
    always @(negedge i_clk) begin
        if (no_gaps) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 99) < 70) ||
                             ($urandom_range(0, 99) < 10 && out_ch.ready);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_command('{out_ch.left_pwm, out_ch.right_pwm, out_ch.drive_dir,
                               out_ch.left_lamp, out_ch.right_lamp, out_ch.rear_lamp,
                               out_ch.alarm});
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("joystick_polar_differential_drive verification failed");
            $finish;
        end
    end

    task automatic send_sample(logic [9:0] sx, logic [9:0] sy, logic [15:0] echo);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.stick_x = sx;
        in_ch.stick_y = sy;
        in_ch.echo_time_us = echo;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sample(sx, sy, echo);
        @(negedge i_clk);
    endtask

    // Lets the block drain completely before registers change.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (sb.pending_cmds.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic random_samples(int count);
        logic [9:0] sx, sy;
        logic [15:0] echo;
        int r;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            sx = $urandom_range(0, 1023);
            sy = $urandom_range(0, 1023);
            r = $urandom_range(0, 9);
            // Pull some samples onto the axes, near the centre and onto the diagonals.
            if (r == 0) sx = 10'd512;
            else if (r == 1) sy = 10'd512;
            else if (r == 2) sx = 10'(1024 - int'(sy));
            else if (r == 3) sx = sy;
            else if (r == 4) begin
                sx = 10'(512 + int'($urandom_range(0, 8)) - 4);
                sy = 10'(512 + int'($urandom_range(0, 8)) - 4);
            end
            if ($urandom_range(0, 1) == 0) echo = $urandom_range(0, 65535);
            else echo = 16'(int'(sb.stop_echo) + int'($urandom_range(0, 4)) - 2);
            send_sample(sx, sy, echo);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_STOP_ECHO;
        i_cfg_data = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.stick_x = 10'd512;
        in_ch.stick_y = 10'd512;
        in_ch.echo_time_us = 16'd0;
        out_ch.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: centre, axis ends, exact 90/180/270/0, diagonals, blocked forward,
        // echo right at the threshold, horizontal-only holds, corners for saturation.
        send_sample(10'd512, 10'd512, 16'd1000);
        send_sample(10'd512, 10'd1023, 16'd65535);
        send_sample(10'd0, 10'd512, 16'd0);
        send_sample(10'd1023, 10'd512, 16'd0);
        send_sample(10'd512, 10'd0, 16'd0);
        send_sample(10'd1023, 10'd1023, 16'd295);
        send_sample(10'd0, 10'd1023, 16'd294);
        send_sample(10'd0, 10'd0, 16'd0);
        send_sample(10'd1023, 10'd0, 16'd0);
        send_sample(10'd700, 10'd700, 16'd0);
        send_sample(10'd300, 10'd900, 16'd5000);
        send_sample(10'd600, 10'd513, 16'd5000);
        send_sample(10'd400, 10'd511, 16'd5000);
        send_sample(10'd513, 10'd512, 16'd5000);
        send_sample(10'd512, 10'd513, 16'd5000);
        send_sample(10'd512, 10'd511, 16'd5000);
        send_sample(10'd511, 10'd512, 16'd5000);
        send_sample(10'd800, 10'd600, 16'd65535);
        send_sample(10'd100, 10'd200, 16'd65535);
        send_sample(10'd512, 10'd512, 16'd0);
        random_samples(400);

        settle();
        write_cfg(CFG_STOP_ECHO, 16'd0);
        write_cfg(CFG_SPEED_FLOOR, 16'd0);
        write_cfg(CFG_SPEED_TOP, 16'd255);
        write_cfg(CFG_UNUSED, 16'hFFFF);
        send_sample(10'd1023, 10'd1023, 16'd0);
        send_sample(10'd0, 10'd0, 16'd1);
        random_samples(400);

        settle();
        write_cfg(CFG_STOP_ECHO, 16'hFFFF);
        write_cfg(CFG_SPEED_FLOOR, 16'hFFFF);
        write_cfg(CFG_SPEED_TOP, 16'd0);
        random_samples(400);

        settle();
        write_cfg(CFG_STOP_ECHO, 16'd1000);
        write_cfg(CFG_SPEED_FLOOR, 16'd255);
        write_cfg(CFG_SPEED_TOP, 16'd255);
        random_samples(400);

        settle();
        write_cfg(CFG_STOP_ECHO, $urandom_range(0, 65535));
        write_cfg(CFG_SPEED_FLOOR, $urandom_range(0, 65535));
        write_cfg(CFG_SPEED_TOP, $urandom_range(0, 65535));
        random_samples(400);

        settle();
        if (sb.mismatches == 0) begin
            $display("joystick_polar_differential_drive verification clean");
        end else begin
            $display("joystick_polar_differential_drive verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
hdl/jpdd_pkg.sv
hdl/jpdd_in_if.sv
hdl/jpdd_out_if.sv
hdl/joystick_polar_differential_drive.sv
dv/tb_top.sv
